// ===== src/idmrc_pkg.sv =====
// Package for the interval-DP minimum release cost block.
// Field widths, reset value, split bias and default capacity. No dependencies.
`timescale 1ns / 1ps

package idmrc_pkg;

  localparam int CELL_W   = 16;  // cut positions and total_cells
  localparam int COST_W   = 32;  // interval costs, wrap modulo 2^32

  localparam int MAX_CUTS_DEFAULT = 128;

  localparam logic [CELL_W-1:0] TOTAL_CELLS_RST = CELL_W'(1);

  // Each release of a span costs its inner width: boundary gap minus 2.
  localparam logic [COST_W-1:0] SPLIT_BIAS = COST_W'(2);

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [COST_W-1:0] cost_t;

endpackage

// ===== src/interval_dp_min_release_cost.sv =====
// Top level of the interval-DP minimum release cost block.
// Depends on idmrc_pkg; holds the position store and cost table memories.
`timescale 1ns / 1ps

// Cut positions are loaded one beat per cycle with start (taken when busy is
// low); the beat with last_item_i set closes the set. Positions beyond
// MAX_CUTS are dropped and flagged in overflow_error_o. After the last beat
// the block holds busy high while it places the two sentinels, seeds the
// adjacent intervals and then solves every wider interval (lo, hi), one
// split point per cycle from a two-read-port cost table plus a drain and a
// write-back step per interval, the bulk of the work being the single
// split-point loop over the cost memory. min_total_cost_o and
// overflow_error_o are valid for exactly one cycle while result_valid_o is
// high; there is no back-pressure on the result, so the receiver must take
// it in that cycle. busy falls in the same cycle, and a new set may start at
// once. total_cells is written through the cfg channel (always ready); the
// user must write it only while the block is idle, which the block itself
// does not enforce. It keeps its value across sets.
module interval_dp_min_release_cost #(
  parameter int MAX_CUTS = idmrc_pkg::MAX_CUTS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item channel
  input  logic                         start,
  output logic                         busy,
  input  logic [idmrc_pkg::CELL_W-1:0] cut_position_i,
  input  logic                         last_item_i,
  // config channel: total_cells
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [idmrc_pkg::CELL_W-1:0] cfg_data_i,
  // result strobe
  output logic                         result_valid_o,
  output logic [idmrc_pkg::COST_W-1:0] min_total_cost_o,
  output logic                         overflow_error_o
);
  import idmrc_pkg::*;

  localparam int BOUNDS = MAX_CUTS + 2;               // positions plus sentinels
  localparam int IW     = $clog2(BOUNDS);             // boundary index width
  localparam int CW     = $clog2(MAX_CUTS + 1);       // loaded count width
  localparam int AW     = $clog2(BOUNDS * BOUNDS);    // cost table address width
  localparam int TDEPTH = BOUNDS * BOUNDS;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SENT0 = 3'd1;  // write left sentinel
  localparam logic [2:0] S_SENT1 = 3'd2;  // write right sentinel
  localparam logic [2:0] S_INIT  = 3'd3;  // adjacent intervals cost 0
  localparam logic [2:0] S_ISSUE = 3'd4;  // one split point per cycle
  localparam logic [2:0] S_DRAIN = 3'd5;  // last read data folds into min
  localparam logic [2:0] S_WRITE = 3'd6;  // write back interval cost

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  cell_t         total_cells_q;
  logic [IW-1:0] last_q, last_d;          // index of right sentinel
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  cost_t         best_q, best_d;
  cost_t         diff_q;
  logic          rd_vld_q;
  logic          res_vld_q;
  cost_t         res_cost_q;
  logic          res_ovf_q;

  // memories
  cell_t         pos_mem [BOUNDS];
  cost_t         cost_mem [TDEPTH];
  cell_t         pos_lo_rd_q, pos_hi_rd_q;
  cost_t         left_rd_q, right_rd_q;

  logic          accept;
  logic          full;
  logic          pos_we;
  logic [IW-1:0] pos_waddr;
  cell_t         pos_wdata;
  logic          cost_we;
  logic [AW-1:0] cost_waddr;
  cost_t         cost_wdata;
  logic [AW-1:0] left_raddr, right_raddr;
  cost_t         split_sum;
  cost_t         span_cost;
  logic          final_write;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign full        = (count_q == CW'(MAX_CUTS));

  // row-major table: entry (r, c) at r*BOUNDS + c
  assign left_raddr  = AW'(lo_q) * AW'(BOUNDS) + AW'(mid_q);
  assign right_raddr = AW'(mid_q) * AW'(BOUNDS) + AW'(hi_q);
  assign cost_waddr  = AW'(lo_q) * AW'(BOUNDS) + AW'(hi_q);

  assign split_sum   = left_rd_q + right_rd_q;
  assign span_cost   = best_q + diff_q;
  assign final_write = (state_q == S_WRITE) && (lo_q == '0) && (hi_q == last_q);

  // position store write port
  always_comb begin
    pos_we    = 1'b0;
    pos_waddr = IW'(count_q) + IW'(1);
    pos_wdata = cut_position_i;
    case (state_q)
      S_IDLE: begin
        pos_we = accept && !full;
      end
      S_SENT0: begin
        pos_we    = 1'b1;
        pos_waddr = '0;
        pos_wdata = '0;
      end
      S_SENT1: begin
        // 16-bit sentinel: total_cells of 65535 wraps to 0
        pos_we    = 1'b1;
        pos_waddr = last_q;
        pos_wdata = total_cells_q + CELL_W'(1);
      end
      default: begin
        pos_we = 1'b0;
      end
    endcase
  end

  // cost table write port
  always_comb begin
    cost_we    = 1'b0;
    cost_wdata = '0;
    case (state_q)
      S_INIT: begin
        cost_we = 1'b1;
      end
      S_WRITE: begin
        cost_we    = 1'b1;
        cost_wdata = span_cost;
      end
      default: begin
        cost_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    last_d  = last_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    best_d  = best_q;

    if (rd_vld_q && (split_sum < best_q)) begin
      best_d = split_sum;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
          end
          if (last_item_i) begin
            last_d  = IW'(count_d) + IW'(1);
            state_d = S_SENT0;
          end
        end
      end
      S_SENT0: begin
        state_d = S_SENT1;
      end
      S_SENT1: begin
        lo_d    = '0;
        hi_d    = IW'(1);
        state_d = S_INIT;
      end
      S_INIT: begin
        if (hi_q == last_q) begin
          lo_d    = '0;
          hi_d    = IW'(2);
          mid_d   = IW'(1);
          best_d  = '1;
          state_d = S_ISSUE;
        end else begin
          lo_d = lo_q + IW'(1);
          hi_d = hi_q + IW'(1);
        end
      end
      S_ISSUE: begin
        if (mid_q == hi_q - IW'(1)) begin
          state_d = S_DRAIN;
        end else begin
          mid_d = mid_q + IW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        best_d = '1;
        if (final_write) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end else if (hi_q == last_q) begin
          // next span width starts at the left sentinel
          lo_d    = '0;
          hi_d    = last_q - lo_q + IW'(1);
          mid_d   = IW'(1);
          state_d = S_ISSUE;
        end else begin
          lo_d    = lo_q + IW'(1);
          hi_d    = hi_q + IW'(1);
          mid_d   = lo_q + IW'(2);
          state_d = S_ISSUE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      ovf_q         <= 1'b0;
      total_cells_q <= TOTAL_CELLS_RST;
      rd_vld_q      <= 1'b0;
      res_vld_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      rd_vld_q  <= (state_q == S_ISSUE);
      res_vld_q <= final_write;
      if (cfg_valid_i && cfg_ready_o) begin
        total_cells_q <= cfg_data_i;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    best_q <= best_d;
    diff_q <= COST_W'(pos_hi_rd_q) - COST_W'(pos_lo_rd_q) - SPLIT_BIAS;
    if (final_write) begin
      res_cost_q <= span_cost;
      res_ovf_q  <= ovf_q;
    end
  end

  // position store: one write, two reads at the interval ends
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_lo_rd_q <= pos_mem[lo_q];
    pos_hi_rd_q <= pos_mem[hi_q];
  end

  // cost table: one write, reads of the left and right sub-intervals.
  // A write-back lands before the next ISSUE cycle reads, so no forwarding.
  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem[cost_waddr] <= cost_wdata;
    end
    left_rd_q  <= cost_mem[left_raddr];
    right_rd_q <= cost_mem[right_raddr];
  end

  assign result_valid_o   = res_vld_q;
  assign min_total_cost_o = res_cost_q;
  assign overflow_error_o = res_ovf_q;

  // checks
  a_res_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && $past(busy))
    else $error("result outside end of compute");

  a_split_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (mid_q > lo_q) && (mid_q < hi_q) && (hi_q <= last_q))
    else $error("split point outside interval");

  a_write_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> $past(state_q == S_DRAIN))
    else $error("write-back without drain");

endmodule

// ===== sim/testbench.sv =====
// Testbench for interval_dp_min_release_cost: drives sets of cut positions,
// predicts each set's minimum release cost and checks every result strobe.
// Depends on idmrc_pkg and the interval_dp_min_release_cost RTL.
`timescale 1ns / 1ps

module testbench;

  import idmrc_pkg::*;

  localparam int MAX_CUTS    = MAX_CUTS_DEFAULT;
  localparam int BOUNDS      = MAX_CUTS + 2;
  localparam int ITEM_TARGET = 1750;
  // The limit covers the slowest legal run (one full-capacity set plus
  // worst-case random sets and sender gaps) with ample margin.
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    cell_t cut;
    logic  last;
  } pos_beat_t;

  typedef struct packed {
    cost_t cost;
    logic  ovf;
  } release_result_t;

  // DUT ports; the inputs are known from time zero
  logic  clk_i          = 1'b0;
  logic  rst_ni         = 1'b0;
  logic  start          = 1'b0;
  logic  busy;
  cell_t cut_position_i = '0;
  logic  last_item_i    = 1'b0;
  logic  cfg_valid_i    = 1'b0;
  logic  cfg_ready_o;
  cell_t cfg_data_i     = '0;
  logic  result_valid_o;
  cost_t min_total_cost_o;
  logic  overflow_error_o;

  // Beats waiting to go out, and expected results in arrival order
  pos_beat_t       pending_beats[$];
  release_result_t cost_q[$];
  pos_beat_t       wire_beat;
  bit              item_on_wire = 1'b0;
  int              beats_queued = 0;

  // Sender burst / gap shaping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Predictor state: own copy of total_cells, held positions and DP table
  cell_t cells_cfg  = TOTAL_CELLS_RST;
  int unsigned held_count = 0;
  bit    held_ovf   = 1'b0;
  cell_t bound_pos [0:BOUNDS-1];
  cost_t span_cost [0:BOUNDS-1][0:BOUNDS-1];

  int fail_count  = 0;
  int cycle_count = 0;
  release_result_t want;

  interval_dp_min_release_cost #(
    .MAX_CUTS(MAX_CUTS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cut_position_i  (cut_position_i),
    .last_item_i     (last_item_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .min_total_cost_o(min_total_cost_o),
    .overflow_error_o(overflow_error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    // keep the log bounded if the block is badly off
    if (fail_count < 100) $display("%0t ns  mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Interval DP over boundaries 0..nb-1. Adjacent boundaries cost nothing;
  // a wider span takes the cheapest inner split plus its inner width.
  // Everything wraps at 32 bits, so unordered positions just give garbage.
  function automatic cost_t release_cost(input int unsigned nb);
    cost_t best;
    cost_t pair;
    for (int unsigned lo = 0; lo + 1 < nb; lo++) span_cost[lo][lo+1] = '0;
    for (int unsigned w = 2; w < nb; w++) begin
      for (int unsigned lo = 0; lo + w < nb; lo++) begin
        best = '1;
        for (int unsigned mid = lo + 1; mid < lo + w; mid++) begin
          pair = span_cost[lo][mid] + span_cost[mid][lo+w];
          if (pair < best) best = pair;
        end
        span_cost[lo][lo+w] = best + cost_t'(bound_pos[lo+w])
                              - cost_t'(bound_pos[lo]) - SPLIT_BIAS;
      end
    end
    return span_cost[0][nb-1];
  endfunction

  // Called for each accepted beat. Positions beyond capacity are dropped
  // (the last-marked one too) but still close the set.
  task automatic predict_beat(input pos_beat_t b);
    cell_t           right;
    release_result_t exp_res;
    if (held_count < MAX_CUTS) begin
      held_count++;
      bound_pos[held_count] = b.cut;
    end else begin
      held_ovf = 1'b1;
    end
    if (b.last) begin
      right = cells_cfg + cell_t'(1);  // 16-bit: 65535 wraps to 0
      bound_pos[0] = '0;
      bound_pos[held_count+1] = right;
      exp_res.cost = release_cost(held_count + 2);
      exp_res.ovf  = held_ovf;
      cost_q.insert(cost_q.size(), exp_res);
      held_count = 0;
      held_ovf   = 1'b0;
    end
  endtask

  // Driver: one beat on the wire at a time, held until start && !busy.
  // Bursts of random length, each followed by a random gap (often none).
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_beat(wire_beat);
        item_on_wire = 1'b0;
      end
      if (!item_on_wire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          wire_beat      = pending_beats.pop_front();
          item_on_wire   = 1'b1;
          start          <= 1'b1;
          cut_position_i <= wire_beat.cut;
          last_item_i    <= wire_beat.last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so sample every strobe.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (cost_q.size() == 0) begin
        report_mismatch("result strobe with no set outstanding");
      end else begin
        want = cost_q.pop_front();
        if (min_total_cost_o !== want.cost)
          report_mismatch($sformatf("min_total_cost got %0d want %0d",
                                    min_total_cost_o, want.cost));
        if (overflow_error_o !== want.ovf)
          report_mismatch($sformatf("overflow_error got %0b want %0b",
                                    overflow_error_o, want.ovf));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL interval_dp_min_release_cost");
      $finish;
    end
  end

  task automatic queue_beat(input cell_t cut, input logic last);
    pos_beat_t nb_beat;
    nb_beat.cut  = cut;
    nb_beat.last = last;
    pending_beats.insert(pending_beats.size(), nb_beat);
    beats_queued++;
  endtask

  // One set of n positions. Mostly ascending inside the row; noisy sets
  // carry arbitrary 16-bit positions, zero and out-of-range included.
  task automatic queue_set(input int n, input bit noisy);
    int unsigned pos;
    int unsigned step_max;
    pos      = 0;
    step_max = (cells_cfg / n > 0) ? cells_cfg / n : 1;
    for (int k = 0; k < n; k++) begin
      if (noisy) pos = $urandom_range(0, 65535);
      else       pos = pos + $urandom_range(1, step_max);
      queue_beat(cell_t'(pos), k == n - 1);
    end
  endtask

  // total_cells only changes while no set is in flight
  task automatic write_cells(input cell_t value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cells_cfg = value;
  endtask

  // Wait until every beat went out and every result came back; busy drops
  // with the result, so a short pause covers the tail.
  task automatic drain;
    while (pending_beats.size() > 0 || item_on_wire || cost_q.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    int sets;
    int r;
    int n;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset value of total_cells, single and duplicate positions
    queue_beat(16'd1, 1'b1);
    queue_beat(16'd1, 1'b0);
    queue_beat(16'd1, 1'b1);
    drain();

    // Widest row: right sentinel wraps to zero
    write_cells(16'hFFFF);
    queue_beat(16'hFFFF, 1'b1);
    queue_beat(16'd1, 1'b0);
    queue_beat(16'h8000, 1'b0);
    queue_beat(16'hFFFF, 1'b1);
    drain();

    // Short row: plain pair, unordered pair, out of range, every cell cut
    write_cells(16'd10);
    queue_beat(16'd3, 1'b0);
    queue_beat(16'd7, 1'b1);
    queue_beat(16'd9, 1'b0);
    queue_beat(16'd2, 1'b1);
    queue_beat(16'd200, 1'b1);
    for (int k = 1; k <= 10; k++) queue_beat(cell_t'(k), k == 10);
    drain();

    // Random phases: new row length, then a few sets
    phase = 0;
    while (beats_queued < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      if (r == 0)      write_cells(16'd1);
      else if (r == 1) write_cells(16'hFFFF);
      else if (r < 6)  write_cells(cell_t'($urandom_range(1, 200)));
      else             write_cells(cell_t'($urandom_range(1, 65535)));
      // one set past capacity: the tail, last-marked beat included, drops
      if (phase == 2) queue_set(MAX_CUTS + 2, 1'b0);
      sets = $urandom_range(1, 6);
      for (int s = 0; s < sets; s++) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                         : $urandom_range(1, 10);
        queue_set(n, $urandom_range(0, 4) == 0);
      end
      drain();
      phase++;
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS interval_dp_min_release_cost");
    end else begin
      $display("FAIL interval_dp_min_release_cost");
    end
    $finish;
  end

endmodule
